// File: rtl/wpa_hs_pkg.sv
// ----------------------------------------------------------------------------
// wpa_hs_pkg
// Types and codes shared by the handshake pair tracker modules.
// ----------------------------------------------------------------------------
package wpa_hs_pkg;

  localparam int unsigned EAPOL_LIMIT_DEF = 256;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned LEN_W = 17;

  localparam logic OP_FRAME   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [1:0] DIR_AP      = 2'd0;
  localparam logic [1:0] DIR_STA     = 2'd1;
  localparam logic [1:0] DIR_UNKNOWN = 2'd2;
  localparam logic [1:0] DIR_NONE    = 2'd3;

  localparam logic [2:0] MSG_NONE = 3'd0;
  localparam logic [2:0] MSG_M1   = 3'd1;
  localparam logic [2:0] MSG_M2   = 3'd2;
  localparam logic [2:0] MSG_M3   = 3'd3;
  localparam logic [2:0] MSG_M4   = 3'd4;

  localparam logic [1:0] AP_NONE = 2'd0;
  localparam logic [1:0] AP_M1   = 2'd1;
  localparam logic [1:0] AP_M3   = 2'd3;

  localparam logic [1:0] STA_NONE = 2'd0;
  localparam logic [1:0] STA_M2   = 2'd2;

  localparam logic [2:0] SRC_NONE = 3'd0;
  localparam logic [2:0] SRC_M2   = 3'd2;
  localparam logic [2:0] SRC_M3   = 3'd3;
  localparam logic [2:0] SRC_M4   = 3'd4;

  // hccapx message pair codes
  localparam logic [2:0] PAIR_M1M2_E2 = 3'd0;
  localparam logic [2:0] PAIR_M1M4_E4 = 3'd1;
  localparam logic [2:0] PAIR_M2M3_E2 = 3'd2;
  localparam logic [2:0] PAIR_M2M3_E3 = 3'd3;
  localparam logic [2:0] PAIR_M3M4_E3 = 3'd4;
  localparam logic [2:0] PAIR_M3M4_E4 = 3'd5;

  typedef struct packed {
    logic             operation;
    logic             is_eapol_key;
    logic [MAC_W-1:0] addr_one;
    logic [MAC_W-1:0] addr_two;
    logic [MAC_W-1:0] addr_three;
    logic             mic_zero;
    logic             nonce_zero;
    logic [LEN_W-1:0] eapol_length;
  } in_item_t;

  typedef struct packed {
    logic       pair_valid;
    logic [2:0] pair_code;
    logic [1:0] direction;
    logic [2:0] message_kind;
    logic       take_ap_nonce;
    logic       take_sta_nonce;
    logic       take_eapol;
    logic       eapol_too_long;
    logic       take_mac_ap;
    logic       take_mac_sta;
  } out_item_t;

  typedef struct packed {
    logic [MAC_W-1:0] station_mac;
    logic [MAC_W-1:0] ap_mac;
    logic [1:0]       ap_progress;
    logic [1:0]       sta_progress;
    logic [2:0]       eapol_source;
    logic             pair_set;
    logic [2:0]       pair_value;
  } trk_state_t;

endpackage

// File: rtl/wpa_handshake_pair_tracker.sv
// ----------------------------------------------------------------------------
// wpa_handshake_pair_tracker
// Classifies captured EAPOL-key frames and tracks the four-way handshake
// message pair.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. A request passes an input register
// and a result register with one step of comparison logic between them, so
// out_valid rises when the request moves on into the result register, which
// waits while a held result blocks it, and one request is accepted every cycle
// while the result side keeps up. Session state changes when a request moves
// into the result register, so back-to-back frames see each other's effect in
// order. A restart request clears the session.
module wpa_handshake_pair_tracker import wpa_hs_pkg::*; #(
  parameter int unsigned MAX_EAPOL_BYTES = EAPOL_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_vld_r;
  in_item_t  in_data_r;
  logic      out_vld_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      adv;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  wpa_hs_core #(
    .MAX_EAPOL_BYTES(MAX_EAPOL_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (in_data_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  a_save_or_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.take_eapol && out_data.eapol_too_long))
    else $error("EAPOL save and refusal together");

  a_mac_sta_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.take_mac_sta) |-> (out_data.direction == DIR_STA))
    else $error("station MAC taken from non-station frame");

  a_m2_nonce: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.message_kind == MSG_M2) |-> out_data.take_sta_nonce)
    else $error("M2 without station nonce strobe");

endmodule

// File: rtl/wpa_hs_core.sv
// ----------------------------------------------------------------------------
// wpa_hs_core
// Session state and per-frame classification; state advances with each
// request moved into the result register.
// ----------------------------------------------------------------------------
module wpa_hs_core import wpa_hs_pkg::*; #(
  parameter int unsigned MAX_EAPOL_BYTES = EAPOL_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_item_t  item,
  output out_item_t result
);

  trk_state_t st_r;
  trk_state_t st_nxt;
  logic       too_long;
  logic       ap_match;
  logic       sta_ok;

  assign too_long = item.eapol_length > LEN_W'(MAX_EAPOL_BYTES);
  assign ap_match = (st_r.station_mac == '0) || (item.addr_one == st_r.station_mac);
  assign sta_ok   = (st_r.station_mac == '0) || (item.addr_two == st_r.station_mac);

  always_comb begin
    st_nxt = st_r;
    result = '0;
    result.direction = DIR_NONE;
    if (item.operation == OP_RESTART) begin
      st_nxt = '0;
    end else if (item.is_eapol_key) begin
      if (item.addr_two == item.addr_three) begin
        result.direction = DIR_AP;
        if (ap_match) begin
          if (st_r.ap_progress == AP_NONE) begin
            st_nxt.ap_mac = item.addr_two;
            result.take_mac_ap = 1'b1;
          end
          if (item.mic_zero) begin
            result.message_kind  = MSG_M1;
            st_nxt.ap_progress   = AP_M1;
            result.take_ap_nonce = 1'b1;
          end else begin
            result.message_kind = MSG_M3;
            if (st_r.ap_progress == AP_NONE) begin
              result.take_ap_nonce = 1'b1;
            end
            st_nxt.ap_progress = AP_M3;
            if (st_r.eapol_source == SRC_M2) begin
              st_nxt.pair_set   = 1'b1;
              st_nxt.pair_value = PAIR_M2M3_E2;
            end else if (too_long) begin
              result.eapol_too_long = 1'b1;
            end else begin
              result.take_eapol   = 1'b1;
              st_nxt.eapol_source = SRC_M3;
              if (st_r.sta_progress == STA_M2) begin
                st_nxt.pair_set   = 1'b1;
                st_nxt.pair_value = PAIR_M2M3_E3;
              end
            end
          end
        end
      end else if (item.addr_one == item.addr_three) begin
        result.direction = DIR_STA;
        if (st_r.station_mac == '0) begin
          st_nxt.station_mac  = item.addr_two;
          result.take_mac_sta = 1'b1;
        end
        if (sta_ok && !item.nonce_zero) begin
          result.message_kind   = MSG_M2;
          st_nxt.sta_progress   = STA_M2;
          result.take_sta_nonce = 1'b1;
          if (too_long) begin
            result.eapol_too_long = 1'b1;
          end else begin
            result.take_eapol   = 1'b1;
            st_nxt.eapol_source = SRC_M2;
            if (st_r.ap_progress == AP_M1) begin
              st_nxt.pair_set   = 1'b1;
              st_nxt.pair_value = PAIR_M1M2_E2;
            end
          end
        end else if (sta_ok) begin
          if (!(st_r.sta_progress == STA_M2 && st_r.eapol_source != SRC_NONE) &&
              st_r.ap_progress != AP_NONE) begin
            result.message_kind = MSG_M4;
            if (st_r.eapol_source == SRC_M3) begin
              st_nxt.pair_set   = 1'b1;
              st_nxt.pair_value = PAIR_M3M4_E3;
            end else if (too_long) begin
              result.eapol_too_long = 1'b1;
            end else begin
              result.take_eapol   = 1'b1;
              st_nxt.eapol_source = SRC_M4;
              if (st_r.ap_progress == AP_M1) begin
                st_nxt.pair_set   = 1'b1;
                st_nxt.pair_value = PAIR_M1M4_E4;
              end
              if (st_r.ap_progress == AP_M3) begin
                st_nxt.pair_set   = 1'b1;
                st_nxt.pair_value = PAIR_M3M4_E4;
              end
            end
          end
        end
      end else begin
        result.direction = DIR_UNKNOWN;
      end
    end
    result.pair_valid = st_nxt.pair_set;
    result.pair_code  = st_nxt.pair_set ? st_nxt.pair_value : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wpa_handshake_pair_tracker. Requests come from a
// queue that holds a short directed list and then random handshake sessions,
// stray frames and restarts. A model of the session state predicts each
// result when its request is accepted. Results are compared in order. Both
// sides idle at random, and one long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module tb;
  import wpa_hs_pkg::*;

  localparam int unsigned MAX_EAPOL_BYTES = EAPOL_LIMIT_DEF;
  localparam int          FRAME_TARGET    = 950;
  localparam int          HOLD_AT         = 400;
  localparam int          HOLD_LEN        = 120;
  localparam logic [MAC_W-1:0] MAC_ONES   = {MAC_W{1'b1}};

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  logic recv_pause = 1'b0;
  logic hold_off = 1'b0;

  in_item_t   pending_q[$];
  out_item_t  frame_results_q[$];
  trk_state_t sess;

  logic [MAC_W-1:0] ap_addr;
  logic [MAC_W-1:0] sta_addr;

  int sent_cnt = 0;
  int res_cnt = 0;
  int err_cnt = 0;
  int mism_cnt = 0;
  int work_cnt = 0;
  int gap_left = 0;
  int send_calm = 0;
  int pause_left = 0;
  int recv_calm = 0;
  int hold_cnt = 0;
  logic hold_armed = 1'b1;
  out_item_t want;

  always #5 clk = ~clk;

  assign out_stall = recv_pause | hold_off;

  wpa_handshake_pair_tracker #(
    .MAX_EAPOL_BYTES(MAX_EAPOL_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // ---------------- session model ----------------

  function automatic void mark_pair(logic [2:0] code);
    sess.pair_set = 1'b1;
    sess.pair_value = code;
  endfunction

  function automatic logic body_fits(input logic [LEN_W-1:0] len, inout out_item_t r);
    if (len > LEN_W'(MAX_EAPOL_BYTES)) begin
      r.eapol_too_long = 1'b1;
      return 1'b0;
    end
    r.take_eapol = 1'b1;
    return 1'b1;
  endfunction

  function automatic out_item_t track_frame(in_item_t f);
    out_item_t r;
    r = '0;
    r.direction = DIR_NONE;
    if (f.operation == OP_RESTART) begin
      sess = '0;
    end else if (f.is_eapol_key) begin
      if (f.addr_two == f.addr_three) begin
        r.direction = DIR_AP;
        if (sess.station_mac == '0 || f.addr_one == sess.station_mac) begin
          if (sess.ap_progress == AP_NONE) begin
            sess.ap_mac = f.addr_two;
            r.take_mac_ap = 1'b1;
          end
          if (f.mic_zero) begin
            r.message_kind = MSG_M1;
            sess.ap_progress = AP_M1;
            r.take_ap_nonce = 1'b1;
          end else begin
            r.message_kind = MSG_M3;
            if (sess.ap_progress == AP_NONE) r.take_ap_nonce = 1'b1;
            sess.ap_progress = AP_M3;
            if (sess.eapol_source == SRC_M2) begin
              mark_pair(PAIR_M2M3_E2);
            end else if (body_fits(f.eapol_length, r)) begin
              sess.eapol_source = SRC_M3;
              if (sess.sta_progress == STA_M2) mark_pair(PAIR_M2M3_E3);
            end
          end
        end
      end else if (f.addr_one == f.addr_three) begin
        r.direction = DIR_STA;
        if (sess.station_mac == '0) begin
          sess.station_mac = f.addr_two;
          r.take_mac_sta = 1'b1;
        end
        if (f.addr_two == sess.station_mac) begin
          if (!f.nonce_zero) begin
            r.message_kind = MSG_M2;
            sess.sta_progress = STA_M2;
            r.take_sta_nonce = 1'b1;
            if (body_fits(f.eapol_length, r)) begin
              sess.eapol_source = SRC_M2;
              if (sess.ap_progress == AP_M1) mark_pair(PAIR_M1M2_E2);
            end
          end else if (!(sess.sta_progress == STA_M2 && sess.eapol_source != SRC_NONE) &&
                       sess.ap_progress != AP_NONE) begin
            r.message_kind = MSG_M4;
            if (sess.eapol_source == SRC_M3) begin
              mark_pair(PAIR_M3M4_E3);
            end else if (body_fits(f.eapol_length, r)) begin
              sess.eapol_source = SRC_M4;
              if (sess.ap_progress == AP_M1) mark_pair(PAIR_M1M4_E4);
              if (sess.ap_progress == AP_M3) mark_pair(PAIR_M3M4_E4);
            end
          end
        end
      end else begin
        r.direction = DIR_UNKNOWN;
      end
    end
    r.pair_valid = sess.pair_set;
    r.pair_code = sess.pair_set ? sess.pair_value : 3'd0;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] v;
    do v = {$urandom, $urandom}; while (v[MAC_W-1:0] == '0);
    return v[MAC_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 9))
      0: return LEN_W'($urandom_range(257, 65539));
      1: return LEN_W'($urandom_range(65500, 65539));
      2: return LEN_W'($urandom_range(0, 89));
      default: return LEN_W'($urandom_range(90, 256));
    endcase
  endfunction

  function automatic in_item_t mk_item(logic op, logic key, logic [MAC_W-1:0] a1,
                                       logic [MAC_W-1:0] a2, logic [MAC_W-1:0] a3,
                                       logic mic0, logic non0, logic [LEN_W-1:0] len);
    in_item_t it;
    it.operation = op;
    it.is_eapol_key = key;
    it.addr_one = a1;
    it.addr_two = a2;
    it.addr_three = a3;
    it.mic_zero = mic0;
    it.nonce_zero = non0;
    it.eapol_length = len;
    return it;
  endfunction

  function automatic in_item_t ap_msg(logic mic0, logic [LEN_W-1:0] len);
    return mk_item(OP_FRAME, 1'b1, sta_addr, ap_addr, ap_addr, mic0, rand_bit(), len);
  endfunction

  function automatic in_item_t sta_msg(logic non0, logic [LEN_W-1:0] len);
    return mk_item(OP_FRAME, 1'b1, ap_addr, sta_addr, ap_addr, rand_bit(), non0, len);
  endfunction

  function automatic in_item_t restart_item();
    return mk_item(OP_RESTART, rand_bit(), rand_mac(), rand_mac(), rand_mac(),
                   rand_bit(), rand_bit(), rand_len());
  endfunction

  task automatic add(in_item_t it);
    pending_q.push_back(it);
    if (it.operation == OP_RESTART || it.is_eapol_key) work_cnt++;
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 4))
      0: add(mk_item(OP_FRAME, 1'b0, rand_mac(), rand_mac(), rand_mac(),
                     rand_bit(), rand_bit(), rand_len()));
      1: add(mk_item(OP_FRAME, 1'b1, rand_mac(), rand_mac(), rand_mac(),
                     rand_bit(), rand_bit(), rand_len()));
      2: add(restart_item());
      3: add(mk_item(OP_FRAME, 1'b1, ap_addr, '0, ap_addr, rand_bit(),
                     rand_bit(), rand_len()));
      default: add(mk_item(OP_FRAME, 1'b1, rand_mac(), ap_addr, ap_addr, rand_bit(),
                           rand_bit(), rand_len()));
    endcase
  endtask

  task automatic add_session();
    int n;
    if ($urandom_range(0, 3) != 0) add(restart_item());
    if ($urandom_range(0, 2) != 0) begin
      ap_addr = rand_mac();
      sta_addr = rand_mac();
    end
    if ($urandom_range(0, 1) == 0) begin
      // handshake in order, some messages dropped
      if ($urandom_range(0, 4) != 0) add(ap_msg(1'b1, rand_len()));
      if ($urandom_range(0, 4) != 0) add(sta_msg(1'b0, rand_len()));
      if ($urandom_range(0, 4) != 0) add(ap_msg(1'b0, rand_len()));
      if ($urandom_range(0, 4) != 0) add(sta_msg(1'b1, rand_len()));
    end else begin
      n = $urandom_range(2, 6);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1: add(ap_msg(1'b1, rand_len()));
          2, 3: add(sta_msg(1'b0, rand_len()));
          4, 5: add(ap_msg(1'b0, rand_len()));
          6, 7: add(sta_msg(1'b1, rand_len()));
          8: add(mk_item(OP_FRAME, 1'b1, ap_addr, rand_mac(), ap_addr, rand_bit(),
                         rand_bit(), rand_len()));
          default: add(mk_item(OP_FRAME, 1'b1, rand_mac(), ap_addr, ap_addr,
                               rand_bit(), rand_bit(), rand_len()));
        endcase
      end
    end
  endtask

  function automatic string show(out_item_t r);
    return $sformatf({"pv=%0d pc=%0d dir=%0d kind=%0d apn=%0b stan=%0b eap=%0b",
                      " long=%0b mac_ap=%0b mac_sta=%0b"},
                     r.pair_valid, r.pair_code, r.direction, r.message_kind, r.take_ap_nonce,
                     r.take_sta_nonce, r.take_eapol, r.eapol_too_long, r.take_mac_ap,
                     r.take_mac_sta);
  endfunction

  // ---------------- request driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        frame_results_q.push_back(track_frame(in_data));
        sent_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      recv_pause <= 1'b0;
      pause_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (frame_results_q.size() == 0) begin
          err_cnt++;
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("result %0d with no request pending: %s", res_cnt, show(out_data));
        end else begin
          want = frame_results_q.pop_front();
          if (out_data !== want) begin
            err_cnt++;
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("result %0d mismatch\n  expected %s\n  actual   %s",
                       res_cnt, show(want), show(out_data));
          end
        end
        pause_left = draw_gap(recv_calm);
      end
      if (pause_left > 0) begin
        pause_left--;
        recv_pause <= 1'b1;
      end else begin
        recv_pause <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_cnt = 0;
    end else if (hold_armed && sent_cnt >= HOLD_AT) begin
      hold_armed = 1'b0;
      hold_cnt = HOLD_LEN;
      hold_off <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      if (hold_cnt == 0) hold_off <= 1'b0;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    sess = '0;
    ap_addr = 48'h02_11_22_33_44_55;
    sta_addr = 48'h0A_66_77_88_99_AA;

    add(mk_item(OP_RESTART, 1'b1, MAC_ONES, MAC_ONES, MAC_ONES, 1'b1, 1'b1, 17'd65539));
    add(mk_item(OP_FRAME, 1'b0, MAC_ONES, MAC_ONES, MAC_ONES, 1'b1, 1'b1, 17'd65539));
    add(mk_item(OP_FRAME, 1'b1, '0, '0, '0, 1'b0, 1'b0, 17'd0));
    add(mk_item(OP_RESTART, 1'b0, '0, '0, '0, 1'b0, 1'b0, 17'd0));
    add(ap_msg(1'b1, 17'd0));
    add(sta_msg(1'b0, 17'd256));
    add(ap_msg(1'b0, 17'd300));
    add(sta_msg(1'b1, 17'd120));
    add(restart_item());
    add(ap_msg(1'b0, 17'd256));           // M3 with no earlier AP message
    add(sta_msg(1'b1, 17'd65539));
    add(restart_item());
    add(sta_msg(1'b1, 17'd100));          // M4 before any AP message
    add(sta_msg(1'b0, 17'd65539));        // over-length M2
    add(ap_msg(1'b1, 17'd100));
    add(sta_msg(1'b1, 17'd120));
    add(mk_item(OP_FRAME, 1'b1, ap_addr, MAC_ONES, ap_addr, 1'b0, 1'b0, 17'd100));
    add(mk_item(OP_FRAME, 1'b1, MAC_ONES, ap_addr, ap_addr, 1'b1, 1'b0, 17'd100));
    add(mk_item(OP_FRAME, 1'b1, 48'h1, 48'h2, 48'h3, 1'b0, 1'b1, 17'd100));
    add(restart_item());
    add(ap_msg(1'b0, 17'd257));           // over-length M3
    add(sta_msg(1'b1, 17'd256));
    add(restart_item());
    add(mk_item(OP_FRAME, 1'b1, ap_addr, '0, ap_addr, 1'b0, 1'b0, 17'd100));
    add(sta_msg(1'b0, 17'd90));

    while (work_cnt < FRAME_TARGET) begin
      if ($urandom_range(0, 4) == 0) add_noise();
      else add_session();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout: %0d requests sent, %0d results seen", sent_cnt, res_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
